@@ hw/rtl/llpa_pkg.sv @@
package llpa_pkg;

  localparam int unsigned LOAD_W    = 24;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned ENG_W     = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned RECIP_W   = 17;
  localparam int unsigned PROD_W    = TIME_W + RECIP_W;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  localparam logic FUNC_ASSIGN = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic REG_ENGINE_COUNT = 1'b0;
  localparam logic REG_SPLIT_ENABLE = 1'b1;

  typedef struct packed {
    logic clear;
    logic scan_init;
    logic scan_step;
    logic div_mul;
    logic div_fix;
    logic add_all;
    logic add_best;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_split;
    logic scan_last;
  } status_t;

  // floor(2^16 / n) for n in 1..16
  function automatic logic [RECIP_W-1:0] recip(input logic [4:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21845;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13107;
      5'd6:    r = 17'd10922;
      5'd7:    r = 17'd9362;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7281;
      5'd10:   r = 17'd6553;
      5'd11:   r = 17'd5957;
      5'd12:   r = 17'd5461;
      5'd13:   r = 17'd5041;
      5'd14:   r = 17'd4681;
      5'd15:   r = 17'd4369;
      5'd16:   r = 17'd4096;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + (LOAD_W+1)'(b);
    return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
  endfunction

endpackage

@@ hw/rtl/llpa_in_if.sv @@
interface llpa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [llpa_pkg::TIME_W-1:0] pass_time;
  logic                        split_capable;

  modport source (output valid, func, pass_time, split_capable, input ready);
  modport sink   (input valid, func, pass_time, split_capable, output ready);
endinterface

@@ hw/rtl/llpa_out_if.sv @@
interface llpa_out_if;
  logic                       valid;
  logic                       ready;
  logic [llpa_pkg::ENG_W-1:0] assigned_engine;
  logic                       split_used;

  modport source (output valid, assigned_engine, split_used, input ready);
  modport sink   (input valid, assigned_engine, split_used, output ready);
endinterface

@@ hw/rtl/llpa_cfg_regs.sv @@
module llpa_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llpa_pkg::APB_AW-1:0] paddr,
  input  logic [llpa_pkg::APB_DW-1:0] pwdata,
  output logic [llpa_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [llpa_pkg::CNT_W-1:0]  engine_count_o,
  output logic                        split_enable_o
);

  logic [llpa_pkg::CNT_W-1:0] engine_count_q;
  logic                       split_enable_q;
  logic                       wr_en;
  logic                       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      engine_count_q <= llpa_pkg::CNT_W'(1);
      split_enable_q <= 1'b0;
    end else if (wr_en) begin
      if (reg_idx == llpa_pkg::REG_ENGINE_COUNT) begin
        engine_count_q <= pwdata[llpa_pkg::CNT_W-1:0];
      end else begin
        split_enable_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (reg_idx == llpa_pkg::REG_SPLIT_ENABLE) begin
      prdata = llpa_pkg::APB_DW'(split_enable_q);
    end else begin
      prdata = llpa_pkg::APB_DW'(engine_count_q);
    end
  end

  assign engine_count_o = engine_count_q;
  assign split_enable_o = split_enable_q;

endmodule

@@ hw/rtl/llpa_ctrl.sv @@
module llpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  llpa_pkg::status_t status_i,
  output llpa_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_ADDALL = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_DONE;
        end else if (status_i.is_split) begin
          cmd_o.div_mul = 1'b1;
          state_d       = S_DIV;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_DIV: begin
        cmd_o.div_fix = 1'b1;
        state_d       = S_ADDALL;
      end
      S_ADDALL: begin
        cmd_o.add_all = 1'b1;
        state_d       = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_best = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/llpa_datapath.sv @@
module llpa_datapath #(
  parameter int unsigned MAX_ENGINES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_load_i,
  input  logic                        func_i,
  input  logic [llpa_pkg::TIME_W-1:0] pass_time_i,
  input  logic                        split_capable_i,
  input  logic [llpa_pkg::CNT_W-1:0]  engine_count_i,
  input  logic                        split_enable_i,
  input  llpa_pkg::cmd_t              cmd_i,
  output llpa_pkg::status_t           status_o,
  output logic [llpa_pkg::ENG_W-1:0]  assigned_engine_o,
  output logic                        split_used_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENGINES);
  localparam int unsigned NUM_W = $clog2(MAX_ENGINES + 1);
  localparam logic [4:0]  MAX5  = 5'(MAX_ENGINES);

  localparam int unsigned LW = llpa_pkg::LOAD_W;
  localparam int unsigned TW = llpa_pkg::TIME_W;

  logic                        func_q;
  logic [TW-1:0]               time_q;
  logic                        cap_q;

  logic [LW-1:0]               load_q [MAX_ENGINES];
  logic [NUM_W-1:0]            idx_q, idx_d;
  logic [IDX_W-1:0]            best_q, best_d;
  logic [LW-1:0]               best_load_q, best_load_d;
  logic [llpa_pkg::PROD_W-1:0] prod_q;
  logic [TW-1:0]               share_q;
  logic [llpa_pkg::ENG_W-1:0]  res_engine_q, out_engine_q;
  logic                        res_split_q, out_split_q;

  logic [4:0]                  cnt5, n5;
  logic [NUM_W-1:0]            n_w;
  logic [NUM_W:0]              idx_nx;
  logic [LW-1:0]               cand;
  logic [TW-1:0]               q0;
  logic [TW+4:0]               q0n;
  logic [TW+4:0]               rem;

  // active engine count, clamped to 1..MAX_ENGINES
  always_comb begin
    cnt5 = 5'(engine_count_i);
    if (cnt5 == 5'd0) begin
      n5 = 5'd1;
    end else if (cnt5 > MAX5) begin
      n5 = MAX5;
    end else begin
      n5 = cnt5;
    end
  end
  assign n_w = n5[NUM_W-1:0];

  assign idx_nx = (NUM_W+1)'(idx_q) + (NUM_W+1)'(1);
  assign cand   = load_q[idx_q[IDX_W-1:0]];

  assign status_o.is_clear  = (func_q == llpa_pkg::FUNC_CLEAR);
  assign status_o.is_split  = cap_q & split_enable_i & (n5 > 5'd1);
  assign status_o.scan_last = (idx_nx >= {1'b0, n_w});

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      func_q <= func_i;
      time_q <= pass_time_i;
      cap_q  <= split_capable_i;
    end
  end

  // truncating divide by reciprocal, one correction step
  assign q0  = prod_q[2*TW-1:TW];
  assign q0n = (TW+5)'(q0) * (TW+5)'(n5);
  assign rem = (TW+5)'(time_q) - q0n;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mul) begin
      prod_q <= llpa_pkg::PROD_W'(time_q) * llpa_pkg::PROD_W'(llpa_pkg::recip(n5));
    end
    if (cmd_i.div_fix) begin
      share_q <= (rem >= (TW+5)'(n5)) ? q0 + TW'(1) : q0;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    best_d      = best_q;
    best_load_d = best_load_q;
    if (cmd_i.scan_init) begin
      idx_d       = NUM_W'(1);
      best_d      = '0;
      best_load_d = load_q[0];
    end else if (cmd_i.scan_step && (idx_q < n_w)) begin
      if (cand < best_load_q) begin
        best_load_d = cand;
        best_d      = idx_q[IDX_W-1:0];
      end
      idx_d = idx_nx[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    best_q      <= best_d;
    best_load_q <= best_load_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENGINES; i++) begin
        load_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < MAX_ENGINES; i++) begin
        load_q[i] <= '0;
      end
    end else if (cmd_i.add_all) begin
      for (int i = 0; i < MAX_ENGINES; i++) begin
        if (NUM_W'(i) < n_w) begin
          load_q[i] <= llpa_pkg::sat_add(load_q[i], share_q);
        end
      end
    end else if (cmd_i.add_best) begin
      load_q[best_q] <= llpa_pkg::sat_add(load_q[best_q], time_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      res_engine_q <= '0;
      res_split_q  <= 1'b0;
    end else if (cmd_i.add_all) begin
      res_engine_q <= '0;
      res_split_q  <= 1'b1;
    end else if (cmd_i.add_best) begin
      res_engine_q <= llpa_pkg::ENG_W'(best_q);
      res_split_q  <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_engine_q <= res_engine_q;
      out_split_q  <= res_split_q;
    end
  end

  assign assigned_engine_o = out_engine_q;
  assign split_used_o      = out_split_q;

endmodule

@@ hw/rtl/least_loaded_pass_assigner_top.sv @@
// Least-loaded pass assigner: one request at a time, one response per request.
// Clear requests zero the loads; split requests take a reciprocal multiply, a
// correction and a parallel add over the active engines; normal requests run
// an argmin that scans one stored load per cycle, then add to the winner.
// An untaken response holds the next.
// Reset clears all engine loads and sets engine_count to 1, split_enable to 0.
module least_loaded_pass_assigner_top #(
  parameter int unsigned MAX_ENGINES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  llpa_in_if.sink                     req_i,
  llpa_out_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llpa_pkg::APB_AW-1:0] paddr,
  input  logic [llpa_pkg::APB_DW-1:0] pwdata,
  output logic [llpa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  logic [llpa_pkg::CNT_W-1:0] engine_count;
  logic                       split_enable;
  llpa_pkg::cmd_t             cmd;
  llpa_pkg::status_t          status;
  logic                       in_ready;

  assign req_i.ready = in_ready;

  llpa_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .engine_count_o (engine_count),
    .split_enable_o (split_enable)
  );

  llpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  llpa_datapath #(
    .MAX_ENGINES (MAX_ENGINES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_load_i         (req_i.valid & in_ready),
    .func_i            (req_i.func),
    .pass_time_i       (req_i.pass_time),
    .split_capable_i   (req_i.split_capable),
    .engine_count_i    (engine_count),
    .split_enable_i    (split_enable),
    .cmd_i             (cmd),
    .status_o          (status),
    .assigned_engine_o (rsp_o.assigned_engine),
    .split_used_o      (rsp_o.split_used)
  );

endmodule

@@ dv/tb_least_loaded_pass_assigner_top.sv @@
`timescale 1ns / 1ps

module tb_least_loaded_pass_assigner_top;

  localparam int unsigned NUM_ENGINES   = 8;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 80;

  class assignment_scoreboard;
    typedef struct packed {
      logic [llpa_pkg::ENG_W-1:0] engine;
      logic                       split;
    } assignment_t;

    logic [llpa_pkg::LOAD_W-1:0] engine_load [NUM_ENGINES];
    logic [llpa_pkg::CNT_W-1:0]  engine_count;
    logic                        split_enable;
    assignment_t                 due[$];
    int unsigned                 errors;
    int unsigned                 requests;
    int unsigned                 responses;

    function new();
      foreach (engine_load[i]) engine_load[i] = '0;
      engine_count = llpa_pkg::CNT_W'(1);
      split_enable = 1'b0;
      errors       = 0;
      requests     = 0;
      responses    = 0;
    endfunction

    function logic [llpa_pkg::LOAD_W-1:0] grow(input logic [llpa_pkg::LOAD_W-1:0] a,
                                               input logic [llpa_pkg::LOAD_W-1:0] b);
      logic [llpa_pkg::LOAD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, llpa_pkg::LOAD_MAX}) ? llpa_pkg::LOAD_MAX
                                              : s[llpa_pkg::LOAD_W-1:0];
    endfunction

    function void note_request(input logic fn, input logic [llpa_pkg::TIME_W-1:0] pass_t,
                               input logic cap);
      assignment_t                 a;
      int unsigned                 n;
      int unsigned                 best;
      logic [llpa_pkg::LOAD_W-1:0] share;
      n = (engine_count == 0) ? 1 :
          (engine_count > NUM_ENGINES) ? NUM_ENGINES : engine_count;
      a = '0;
      requests++;
      if (fn == llpa_pkg::FUNC_CLEAR) begin
        foreach (engine_load[i]) engine_load[i] = '0;
      end else if (cap && split_enable && n > 1) begin
        share = llpa_pkg::LOAD_W'(pass_t / n);
        for (int unsigned i = 0; i < n; i++) engine_load[i] = grow(engine_load[i], share);
        a.split = 1'b1;
      end else begin
        best = 0;
        for (int unsigned i = 1; i < n; i++) begin
          if (engine_load[i] < engine_load[best]) best = i;
        end
        engine_load[best] = grow(engine_load[best], llpa_pkg::LOAD_W'(pass_t));
        a.engine = best[llpa_pkg::ENG_W-1:0];
      end
      due.insert(due.size(), a);
    endfunction

    function void check_response(input logic [llpa_pkg::ENG_W-1:0] eng, input logic split);
      assignment_t a;
      responses++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending, engine=%0d split=%0b",
                 $time, eng, split);
        return;
      end
      a = due.pop_front();
      if (eng !== a.engine) begin
        errors++;
        $display("%0t: assigned_engine expected %0d got %0d", $time, a.engine, eng);
      end
      if (split !== a.split) begin
        errors++;
        $display("%0t: split_used expected %0b got %0b", $time, a.split, split);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [llpa_pkg::APB_AW-1:0] paddr;
  logic [llpa_pkg::APB_DW-1:0] pwdata;
  logic [llpa_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  llpa_in_if  req_if ();
  llpa_out_if rsp_if ();

  least_loaded_pass_assigner_top #(
    .MAX_ENGINES(NUM_ENGINES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  assignment_scoreboard sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic        ready_hold   = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= !ready_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      sb.check_response(rsp_if.assigned_engine, rsp_if.split_used);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(input logic fn, input logic [llpa_pkg::TIME_W-1:0] pass_t,
                              input logic cap);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.func          <= fn;
    req_if.pass_time     <= pass_t;
    req_if.split_capable <= cap;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(fn, pass_t, cap);
  endtask

  task automatic wait_all_done();
    req_if.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [llpa_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == llpa_pkg::REG_ENGINE_COUNT) sb.engine_count = value[llpa_pkg::CNT_W-1:0];
    else sb.split_enable = value[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    fork
      begin
        ready_hold <= 1'b1;
        repeat (cycles) @(posedge clk_i);
        ready_hold <= 1'b0;
      end
    join_none
  endtask

  task automatic run_random(input int unsigned count);
    logic                        fn;
    logic [llpa_pkg::TIME_W-1:0] pass_t;
    logic                        cap;
    repeat (count) begin
      fn = ($urandom_range(99) < 8) ? llpa_pkg::FUNC_CLEAR : llpa_pkg::FUNC_ASSIGN;
      case ($urandom_range(3))
        0:       pass_t = llpa_pkg::TIME_W'($urandom_range(15));
        1:       pass_t = llpa_pkg::TIME_W'($urandom_range(65535, 60000));
        default: pass_t = llpa_pkg::TIME_W'($urandom_range(65535));
      endcase
      cap = 1'($urandom_range(1));
      send_request(fn, pass_t, cap);
    end
  endtask

  initial begin
    int unsigned count_plan [9];
    int unsigned k;
    count_plan = '{1, 8, 2, 15, 0, 5, 3, 9, 7};

    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_if.valid         = 1'b0;
    req_if.func          = llpa_pkg::FUNC_ASSIGN;
    req_if.pass_time     = '0;
    req_if.split_capable = 1'b0;
    rsp_if.ready         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one engine, no splitting
    send_request(llpa_pkg::FUNC_ASSIGN, 16'h0000, 1'b0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'hFFFF, 1'b1);
    send_request(llpa_pkg::FUNC_CLEAR, 16'hFFFF, 1'b1);

    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 8);
    write_reg(llpa_pkg::REG_SPLIT_ENABLE, 1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd100, 1'b0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd50, 1'b0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd0, 1'b0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'hFFFF, 1'b1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd7, 1'b1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'hFFFF, 1'b0);
    send_request(llpa_pkg::FUNC_CLEAR, 16'h0000, 1'b0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd8, 1'b1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd300, 1'b0);

    // count of zero behaves as one engine
    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'hFFFF, 1'b1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd1234, 1'b0);

    // count above the engine total is capped
    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 15);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'hFFFF, 1'b1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd3, 1'b0);

    // engines past the count keep their loads
    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 3);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd5000, 1'b0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd9, 1'b1);
    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 9);
    write_reg(llpa_pkg::REG_SPLIT_ENABLE, 0);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'hFFFF, 1'b1);
    send_request(llpa_pkg::FUNC_ASSIGN, 16'd1, 1'b0);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          src_idle_pct = 19;
          snk_idle_pct <= 69;
        end
        1: begin
          src_idle_pct = 69;
          snk_idle_pct <= 19;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct <= 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        k = m * 3 + s;
        wait_all_done();
        write_reg(llpa_pkg::REG_ENGINE_COUNT, count_plan[k]);
        write_reg(llpa_pkg::REG_SPLIT_ENABLE, k % 2);
        if (s == 1) hold_receiver(HOLD_CYCLES);
        run_random(10);
        if (s == 2) wait_all_done();
        run_random(10);
      end
    end

    // drive engine 0 alone into saturation, then spread over two engines
    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 1);
    write_reg(llpa_pkg::REG_SPLIT_ENABLE, 1);
    send_request(llpa_pkg::FUNC_CLEAR, 16'h0000, 1'b0);
    repeat (260) send_request(llpa_pkg::FUNC_ASSIGN,
                              llpa_pkg::TIME_W'($urandom_range(65535, 65000)),
                              1'($urandom_range(1)));
    wait_all_done();
    write_reg(llpa_pkg::REG_ENGINE_COUNT, 2);
    write_reg(llpa_pkg::REG_SPLIT_ENABLE, 0);
    repeat (30) send_request(llpa_pkg::FUNC_ASSIGN,
                             llpa_pkg::TIME_W'($urandom_range(65535, 64000)),
                             1'($urandom_range(1)));
    wait_all_done();
    write_reg(llpa_pkg::REG_SPLIT_ENABLE, 1);
    repeat (10) send_request(llpa_pkg::FUNC_ASSIGN,
                             llpa_pkg::TIME_W'($urandom_range(65535)),
                             1'($urandom_range(1)));
    wait_all_done();

    $display("Run covered %0d requests and %0d responses: engine counts 0 to 15,",
             sb.requests, sb.responses);
    $display("split on and off, clears, idling on both sides, long stalls and load saturation.");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
